// File: design/sed_pkg.sv
`default_nettype none

package sed_pkg;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] error_kind;
    logic       string_end;
  } sed_res_t;

  // results of one accepted byte, handed from the decoder to the result queue
  typedef struct packed {
    logic                valid;
    logic [1:0]          count;
    sed_res_t [1:0]      res;
  } sed_push_t;

  localparam int unsigned QDepth = 3;
  localparam int unsigned LevelW = 2;

  localparam logic [2:0] ModeNormal = 3'd0;
  localparam logic [2:0] ModeEsc    = 3'd1;
  localparam logic [2:0] ModeHex    = 3'd2;
  localparam logic [2:0] ModeOct    = 3'd3;
  localparam logic [2:0] ModeDrop   = 3'd4;

  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrHex   = 2'd1;
  localparam logic [1:0] ErrOct   = 2'd2;
  localparam logic [1:0] ErrTrail = 2'd3;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChA  = 8'h61;
  localparam logic [7:0] ChB  = 8'h62;
  localparam logic [7:0] ChF  = 8'h66;
  localparam logic [7:0] ChN  = 8'h6E;
  localparam logic [7:0] ChR  = 8'h72;
  localparam logic [7:0] ChT  = 8'h74;
  localparam logic [7:0] ChV  = 8'h76;
  localparam logic [7:0] ChX  = 8'h78;
  localparam logic [7:0] Ch0  = 8'h30;
  localparam logic [7:0] Ch7  = 8'h37;
  localparam logic [7:0] Ch8  = 8'h38;
  localparam logic [7:0] Ch9  = 8'h39;

  localparam logic [7:0] CodeBel = 8'h07;
  localparam logic [7:0] CodeBs  = 8'h08;
  localparam logic [7:0] CodeFf  = 8'h0C;
  localparam logic [7:0] CodeLf  = 8'h0A;
  localparam logic [7:0] CodeCr  = 8'h0D;
  localparam logic [7:0] CodeHt  = 8'h09;
  localparam logic [7:0] CodeVt  = 8'h0B;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/string_escape_decoder.sv
`default_nettype none

// Decodes the body of a C string literal, one raw byte per transaction with
// last_byte_i on the final byte, into unescaped bytes. Simple and named
// escapes, \x with one or two hex digits and octal escapes of up to three
// digits are handled; the byte that ends a numeric escape follows its value.
// On an error one result carries error_kind with string_end set and the rest
// of that string is discarded. A byte is taken every cycle while the three-entry
// result queue holds fewer than two results; the queue drains one result per
// cycle while out_stall_i is low. Results are registered into the queue behind
// any results still waiting there.
module string_escape_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      error_kind_o,
  output logic            string_end_o
);
  import sed_pkg::*;

  logic              accept;
  logic              pop;
  sed_push_t         push;
  sed_res_t          head;
  logic [LevelW-1:0] level;

  // room for two results must be there before a byte is taken
  assign in_stall_o  = level >= LevelW'(2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = level != '0;
  assign pop         = out_valid_o && !out_stall_i;

  sed_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  sed_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (level)
  );

  assign out_byte_o   = head.out_byte;
  assign error_kind_o = head.error_kind;
  assign string_end_o = head.string_end;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LevelW'(QDepth))
    else $error("result queue over capacity");

  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && push.count == 2'd2 |=> level >= LevelW'(2))
    else $error("second result lost");

  a_error_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_kind_o != ErrNone |-> string_end_o && out_byte_o == 8'd0)
    else $error("error result without string end");
`endif

endmodule

`default_nettype wire

// File: design/sed_decode.sv
`default_nettype none

module sed_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          last_byte_i,
  output sed_pkg::sed_push_t push_o
);
  import sed_pkg::*;

  logic [2:0] mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  logic [8:0] val_q, val_d;

  logic [1:0]     n;
  sed_res_t [1:0] res;
  logic [1:0]     err;
  logic           skip;
  logic [4:0]     hx;

  always_comb begin
    logic [7:0] c;
    logic       last;
    c     = in_byte_i;
    last  = last_byte_i;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    err    = ErrNone;
    n      = 2'd0;
    res    = '0;
    skip   = 1'b0;
    hx     = hex_digit(c);

    case (mode_q)
      ModeNormal: begin
        if (c == ChBackslash) begin
          mode_d = ModeEsc;
        end else begin
          res[0] = '{out_byte: c, error_kind: ErrNone, string_end: 1'b0};
          n = 2'd1;
        end
      end
      ModeEsc: begin
        mode_d = ModeNormal;
        n = 2'd1;
        case (c)
          ChA: res[0].out_byte = CodeBel;
          ChB: res[0].out_byte = CodeBs;
          ChF: res[0].out_byte = CodeFf;
          ChN: res[0].out_byte = CodeLf;
          ChR: res[0].out_byte = CodeCr;
          ChT: res[0].out_byte = CodeHt;
          ChV: res[0].out_byte = CodeVt;
          ChX: begin
            n      = 2'd0;
            mode_d = ModeHex;
            cnt_d  = 2'd0;
            val_d  = 9'd0;
          end
          Ch8, Ch9: begin
            n   = 2'd0;
            err = ErrOct;
          end
          default: begin
            if (c inside {[Ch0:Ch7]}) begin
              n      = 2'd0;
              mode_d = ModeOct;
              cnt_d  = 2'd1;
              val_d  = {6'd0, c[2:0]};
            end else begin
              res[0].out_byte = c;
            end
          end
        endcase
      end
      ModeHex: begin
        if (hx[4]) begin
          val_d = {val_q[4:0], hx[3:0]};
          cnt_d = cnt_q + 2'd1;
          if (cnt_d >= 2'd2) begin
            res[0].out_byte = val_d[7:0];
            n      = 2'd1;
            mode_d = ModeNormal;
          end
        end else if (cnt_q == 2'd0) begin
          err = ErrHex;
        end else begin
          res[0].out_byte = val_q[7:0];
          res[1].out_byte = c;
          n      = 2'd2;
          mode_d = ModeNormal;
        end
      end
      ModeOct: begin
        if (c inside {[Ch0:Ch7]}) begin
          val_d = {val_q[5:0], c[2:0]};
          cnt_d = cnt_q + 2'd1;
          if (cnt_d == 2'd3 || cnt_d == 2'd0) begin
            if (val_d[8]) begin
              err = ErrOct;
            end else begin
              res[0].out_byte = val_d[7:0];
              n = 2'd1;
            end
            mode_d = ModeNormal;
          end
        end else begin
          // terminator goes out raw after the value
          res[0].out_byte = val_q[7:0];
          res[1].out_byte = c;
          n      = 2'd2;
          mode_d = ModeNormal;
        end
      end
      default: begin
        // dropping the rest of a failed string; digits are left alone
        skip   = 1'b1;
        mode_d = last ? ModeNormal : ModeDrop;
      end
    endcase

    if (!skip) begin
      if (err == ErrNone && last) begin
        if (mode_d == ModeEsc) begin
          err = ErrTrail;
        end else if (mode_d == ModeHex && cnt_d == 2'd0) begin
          err = ErrHex;
        end else if ((mode_d == ModeHex || mode_d == ModeOct) && n != 2'd2) begin
          res[n[0]] = '{out_byte: val_d[7:0], error_kind: ErrNone, string_end: 1'b0};
          n = n + 2'd1;
        end
        if (err == ErrNone) begin
          mode_d = ModeNormal;
        end
      end

      if (err != ErrNone) begin
        if (n != 2'd2) begin
          res[n[0]] = '{out_byte: 8'd0, error_kind: err, string_end: 1'b1};
          n = n + 2'd1;
        end
        mode_d = last ? ModeNormal : ModeDrop;
      end else if (last && n != 2'd0) begin
        res[n[0] ^ 1'b1].string_end = 1'b1;
      end

      if (mode_d == ModeNormal) begin
        cnt_d = 2'd0;
        val_d = 9'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      cnt_q  <= 2'd0;
      val_q  <= 9'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      val_q  <= val_d;
    end
  end

  assign push_o = '{valid: accept_i, count: n, res: res};

endmodule

`default_nettype wire

// File: design/sed_out_queue.sv
`default_nettype none

module sed_out_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sed_pkg::sed_push_t            push_i,
  input  wire logic                          pop_i,
  output sed_pkg::sed_res_t                  head_o,
  output logic [sed_pkg::LevelW-1:0]         level_o
);
  import sed_pkg::*;

  sed_res_t ent_q [QDepth];
  sed_res_t ent_d [QDepth];
  logic [LevelW-1:0] cnt_q, cnt_d;
  logic [LevelW-1:0] base;

  always_comb begin
    base = cnt_q - LevelW'(pop_i);
    for (int i = 0; i < QDepth; i++) begin
      if (pop_i && i < QDepth - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_i.valid && push_i.count != 2'd0 && LevelW'(i) == base) begin
        ent_d[i] = push_i.res[0];
      end
      if (push_i.valid && push_i.count == 2'd2 && LevelW'(i) == base + LevelW'(1)) begin
        ent_d[i] = push_i.res[1];
      end
    end
    cnt_d = push_i.valid ? base + LevelW'(push_i.count) : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o  = ent_q[0];
  assign level_o = cnt_q;

endmodule

`default_nettype wire

// File: test/string_escape_decoder_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the decoded stream from every accepted input
// transaction and compares accepted output transactions in order.
module string_escape_decoder_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic [1:0] error_kind_i,
  input  wire logic       string_end_i,
  output int              fail_count_o,
  output int              pending_o
);
  import sed_pkg::*;

  logic [2:0] dec_mode = ModeNormal;
  logic [1:0] digits_taken = 2'd0;
  logic [8:0] digit_acc = 9'd0;
  sed_res_t   step_res[$];
  sed_res_t   decoded_q[$];
  sed_res_t   want;
  logic       bad;
  int         fails = 0;

  function automatic int hex_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= Ch0 && c <= Ch9) return int'(c - Ch0);
    if (lc >= ChA && lc <= ChF) return int'(lc - ChA) + 10;
    return -1;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c >= Ch0 && c <= Ch7;
  endfunction

  task automatic emit(input logic [7:0] b, input logic [1:0] err, input logic fin);
    sed_res_t r;
    r.out_byte = b;
    r.error_kind = err;
    r.string_end = fin;
    step_res.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [1:0] err;
    int d;
    sed_res_t r;
    err = ErrNone;
    step_res.delete();
    case (dec_mode)
      ModeNormal: begin
        if (c == ChBackslash) dec_mode = ModeEsc;
        else emit(c, ErrNone, 1'b0);
      end
      ModeEsc: begin
        dec_mode = ModeNormal;
        case (c)
          ChA: emit(CodeBel, ErrNone, 1'b0);
          ChB: emit(CodeBs, ErrNone, 1'b0);
          ChF: emit(CodeFf, ErrNone, 1'b0);
          ChN: emit(CodeLf, ErrNone, 1'b0);
          ChR: emit(CodeCr, ErrNone, 1'b0);
          ChT: emit(CodeHt, ErrNone, 1'b0);
          ChV: emit(CodeVt, ErrNone, 1'b0);
          ChX: begin
            dec_mode = ModeHex;
            digits_taken = 2'd0;
            digit_acc = 9'd0;
          end
          Ch8, Ch9: err = ErrOct;
          default: begin
            if (is_octal(c)) begin
              dec_mode = ModeOct;
              digits_taken = 2'd1;
              digit_acc = {6'd0, c[2:0]};
            end else begin
              emit(c, ErrNone, 1'b0);
            end
          end
        endcase
      end
      ModeHex: begin
        d = hex_value(c);
        if (d >= 0) begin
          digit_acc = {digit_acc[4:0], 4'(d)};
          digits_taken = digits_taken + 2'd1;
          if (digits_taken >= 2'd2) begin
            emit(digit_acc[7:0], ErrNone, 1'b0);
            dec_mode = ModeNormal;
          end
        end else if (digits_taken == 2'd0) begin
          err = ErrHex;
        end else begin
          // terminator goes out raw behind the value
          emit(digit_acc[7:0], ErrNone, 1'b0);
          emit(c, ErrNone, 1'b0);
          dec_mode = ModeNormal;
        end
      end
      ModeOct: begin
        if (is_octal(c)) begin
          digit_acc = {digit_acc[5:0], c[2:0]};
          digits_taken = digits_taken + 2'd1;
          if (digits_taken >= 2'd3 || digits_taken == 2'd0) begin
            if (digit_acc > 9'd255) err = ErrOct;
            else emit(digit_acc[7:0], ErrNone, 1'b0);
            dec_mode = ModeNormal;
          end
        end else begin
          emit(digit_acc[7:0], ErrNone, 1'b0);
          emit(c, ErrNone, 1'b0);
          dec_mode = ModeNormal;
        end
      end
      default: begin
        // rest of a failed string: nothing out, final byte rearms
        dec_mode = last ? ModeNormal : ModeDrop;
        return;
      end
    endcase

    if (err == ErrNone && last) begin
      if (dec_mode == ModeEsc) err = ErrTrail;
      else if (dec_mode == ModeHex && digits_taken == 2'd0) err = ErrHex;
      else if (dec_mode == ModeHex || dec_mode == ModeOct) emit(digit_acc[7:0], ErrNone, 1'b0);
      if (err == ErrNone) dec_mode = ModeNormal;
    end

    if (err != ErrNone) begin
      emit(8'h00, err, 1'b1);
      dec_mode = last ? ModeNormal : ModeDrop;
    end else if (last && step_res.size() > 0) begin
      r = step_res.pop_back();
      r.string_end = 1'b1;
      step_res.push_back(r);
    end
    if (dec_mode == ModeNormal) begin
      digits_taken = 2'd0;
      digit_acc = 9'd0;
    end
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_mode = ModeNormal;
      digits_taken = 2'd0;
      digit_acc = 9'd0;
      decoded_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results lag their input, so check before predicting
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected, actual out_byte %h",
                   $time, out_byte_i);
          $display("%0t:   actual error_kind %0d string_end %0b",
                   $time, error_kind_i, string_end_i);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          bad = 1'b0;
          if (out_byte_i !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, out_byte_i);
            bad = 1'b1;
          end
          if (error_kind_i !== want.error_kind) begin
            $display("%0t: error_kind expected %0d actual %0d",
                     $time, want.error_kind, error_kind_i);
            bad = 1'b1;
          end
          if (string_end_i !== want.string_end) begin
            $display("%0t: string_end expected %0b actual %0b",
                     $time, want.string_end, string_end_i);
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_byte_i, last_byte_i);
      fail_count_o <= fails;
      pending_o <= decoded_q.size();
    end
  end

endmodule

// File: test/string_escape_decoder_test.sv
`timescale 1ns / 100ps

module string_escape_decoder_test;
  import sed_pkg::*;

  localparam int RandomBytes = 1300;
  localparam int CycleLimit  = 100000;
  localparam int HoldStart   = 250;
  localparam int HoldCycles  = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] error_kind;
  logic       string_end;
  int         fail_count;
  int         pending;
  logic       steady = 1'b0;
  logic [7:0] str_q[$];
  int         cycles = 0;

  always #5 clk_i = ~clk_i;

  string_escape_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .error_kind_o (error_kind),
    .string_end_o (string_end)
  );

  string_escape_decoder_checker watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .error_kind_i (error_kind),
    .string_end_i (string_end),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("string_escape_decoder test failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin : rx_stall
    int n;
    n = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n++;
      if (n >= HoldStart && n < HoldStart + HoldCycles) out_stall <= 1'b1;
      else if (steady) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_byte <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return Ch0 + 8'(v);
    // lower or upper case letter digit
    return (($urandom_range(0, 1) != 0) ? ChA : ChA - 8'h20) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] named_char(input int i);
    case (i)
      0: return ChA;
      1: return ChB;
      2: return ChF;
      3: return ChN;
      4: return ChR;
      5: return ChT;
      default: return ChV;
    endcase
  endfunction

  task automatic add_token();
    int k;
    int n;
    logic [7:0] b;
    logic [7:0] lc;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      str_q.push_back(8'($urandom_range(0, 255)));
    end else if (k < 42) begin
      str_q.push_back(ChBackslash);
      str_q.push_back(named_char($urandom_range(0, 6)));
    end else if (k < 54) begin
      // up to three digits: a third one is a plain byte
      str_q.push_back(ChBackslash);
      str_q.push_back(ChX);
      n = $urandom_range(1, 3);
      repeat (n) str_q.push_back(rand_hex_char());
    end else if (k < 68) begin
      str_q.push_back(ChBackslash);
      n = $urandom_range(1, 3);
      repeat (n) str_q.push_back(Ch0 + 8'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) == 0) str_q.push_back(($urandom_range(0, 1) != 0) ? Ch8 : Ch9);
    end else if (k < 80) begin
      str_q.push_back(ChBackslash);
      str_q.push_back(8'($urandom_range(0, 255)));
    end else if (k < 85) begin
      b = 8'($urandom_range(0, 255));
      lc = b | 8'h20;
      if ((b >= Ch0 && b <= Ch9) || (lc >= ChA && lc <= ChF)) b = 8'h67;
      str_q.push_back(ChBackslash);
      str_q.push_back(ChX);
      str_q.push_back(b);
    end else if (k < 89) begin
      str_q.push_back(ChBackslash);
      str_q.push_back(($urandom_range(0, 1) != 0) ? Ch8 : Ch9);
    end else if (k < 93) begin
      str_q.push_back(ChBackslash);
      str_q.push_back(ChBackslash);
    end else begin
      str_q.push_back(($urandom_range(0, 1) != 0) ? ChBackslash : ChX);
    end
  endtask

  task automatic build_string();
    int tokens;
    str_q.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) add_token();
    case ($urandom_range(0, 24))
      0: str_q.push_back(ChBackslash);
      1: begin
        str_q.push_back(ChBackslash);
        str_q.push_back(ChX);
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int sent;
    bit paused;
    sent = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes and a named escape
    str_q = {8'h00, 8'hFF, ChBackslash, ChV};
    send_string();
    // hex escape ended by a backslash, which is emitted raw
    str_q = {ChBackslash, ChX, 8'h34, ChBackslash, 8'h71};
    send_string();
    // x without a digit, remaining bytes dropped including the last
    str_q = {ChBackslash, ChX, 8'h67, 8'h7A};
    send_string();
    str_q = {ChBackslash, ChX};
    send_string();
    str_q = {ChBackslash, Ch8};
    send_string();
    str_q = {ChBackslash, Ch9, 8'h71};
    send_string();
    // octal above 255
    str_q = {ChBackslash, Ch7, Ch7, Ch7};
    send_string();
    // second octal digit 8 ends the escape
    str_q = {ChBackslash, 8'h31, Ch8};
    send_string();
    str_q = {ChBackslash};
    send_string();
    // escape cut short by the end of the string
    str_q = {ChBackslash, 8'h31, 8'h32};
    send_string();
    str_q = {ChBackslash, ChX, 8'h46, 8'h66};
    send_string();

    while (sent < RandomBytes) begin
      build_string();
      steady <= (sent >= 400 && sent < 700);
      send_string();
      sent += str_q.size();
      if (!paused && sent >= 900) begin
        drain();
        paused = 1'b1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("string_escape_decoder test passed");
    end else begin
      $display("string_escape_decoder test failed");
    end
    $finish;
  end

endmodule

// File: string_escape_decoder.f
design/sed_pkg.sv
design/sed_decode.sv
design/sed_out_queue.sv
design/string_escape_decoder.sv
test/string_escape_decoder_checker.sv
test/string_escape_decoder_test.sv
